// ===== src/qau_pkg.sv =====
`default_nettype none
package qau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int LANES     = 4;
    localparam int TERMS     = 4;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + 2;

    // Lane pipeline: product, sum of terms, rounding.
    localparam int LANE_LAT = 3;

    // Square root: one result bit per stage, then a rounding stage.
    localparam int SQ_W     = SUM_W;
    localparam int SQ_STEPS = SQ_W / 2;
    localparam int ROOT_W   = SQ_STEPS;
    localparam int SQ_REM_W = SQ_STEPS + 3;
    localparam int SQ_LAT   = SQ_STEPS + 1;

    // Divider: the divisor is a factor, a magnitude or a rounded squared norm.
    localparam int DEN_W   = (PROD_W + 1 - FRAC_BITS > ROOT_W) ?
                             (PROD_W + 1 - FRAC_BITS) : ROOT_W;
    localparam int NUM_W   = ((DATA_W + FRAC_BITS > DEN_W) ?
                             (DATA_W + FRAC_BITS) : DEN_W) + 1;
    localparam int DIV_LAT = NUM_W;

    localparam int PIPE_DEPTH = LANE_LAT + SQ_LAT + DIV_LAT + 2;

    typedef logic [3:0] cmd_t;
    localparam cmd_t CMD_ADD   = 4'd0;
    localparam cmd_t CMD_SUB   = 4'd1;
    localparam cmd_t CMD_MUL   = 4'd2;
    localparam cmd_t CMD_SCALE = 4'd3;
    localparam cmd_t CMD_DIV   = 4'd4;
    localparam cmd_t CMD_DOT   = 4'd5;
    localparam cmd_t CMD_MAG   = 4'd6;
    localparam cmd_t CMD_NORM  = 4'd7;
    localparam cmd_t CMD_INV   = 4'd8;

    typedef logic signed [SUM_W-1:0] val_t;

    // Operands of one lane: term k is x[k] * y[k], subtracted when neg[k] is set.
    typedef struct packed {
        logic [TERMS-1:0][DATA_W-1:0] x;
        logic [TERMS-1:0][DATA_W-1:0] y;
        logic [TERMS-1:0]             neg;
    } lane_op_t;

    // Hamilton product: term k of every lane takes A part k and this B part.
    localparam logic [LANES-1:0][TERMS-1:0][1:0] MUL_BI = {
        {2'd0, 2'd1, 2'd2, 2'd3},
        {2'd1, 2'd0, 2'd3, 2'd2},
        {2'd2, 2'd3, 2'd0, 2'd1},
        {2'd3, 2'd2, 2'd1, 2'd0}
    };
    localparam logic [LANES-1:0][TERMS-1:0] MUL_NEG = {
        4'b0100, 4'b0010, 4'b1000, 4'b1110
    };

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              clamp;
    } sat_t;

    function automatic sat_t sat_val(input val_t v);
        sat_t s;
        val_t hi;
        val_t lo;
        hi = {{(SUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
        lo = ~hi;
        s.clamp = 1'b1;
        if (v > hi) begin
            s.value = {1'b0, {(DATA_W - 1){1'b1}}};
        end else if (v < lo) begin
            s.value = {1'b1, {(DATA_W - 1){1'b0}}};
        end else begin
            s.value = v[DATA_W-1:0];
            s.clamp = 1'b0;
        end
        return s;
    endfunction

    function automatic sat_t sat_quot(input logic [NUM_W-1:0] q, input logic neg);
        sat_t s;
        logic [NUM_W-1:0] lim;
        lim = NUM_W'(1) << (DATA_W - 1);
        s.clamp = 1'b0;
        if (neg) begin
            if (q > lim) begin
                s.value = {1'b1, {(DATA_W - 1){1'b0}}};
                s.clamp = 1'b1;
            end else begin
                s.value = ~q[DATA_W-1:0] + 1'b1;
            end
        end else begin
            if (q >= lim) begin
                s.value = {1'b0, {(DATA_W - 1){1'b1}}};
                s.clamp = 1'b1;
            end else begin
                s.value = q[DATA_W-1:0];
            end
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== src/qau_in_if.sv =====
`default_nettype none
interface qau_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [31:0] a_w;
    logic [31:0] a_x;
    logic [31:0] a_y;
    logic [31:0] a_z;
    logic [31:0] b_w;
    logic [31:0] b_x;
    logic [31:0] b_y;
    logic [31:0] b_z;
    logic [31:0] factor;

    modport source (output valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                    factor, input ready);
    modport sink (input valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  factor, output ready);
endinterface
`default_nettype wire

// ===== src/qau_out_if.sv =====
`default_nettype none
interface qau_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] r_w;
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [31:0] r_z;
    logic [31:0] scalar_result;
    logic        div_by_zero;
    logic        saturated;

    modport source (output valid, r_w, r_x, r_y, r_z, scalar_result, div_by_zero,
                    saturated, input ready);
    modport sink (input valid, r_w, r_x, r_y, r_z, scalar_result, div_by_zero,
                  saturated, output ready);
endinterface
`default_nettype wire

// ===== src/qau_lane.sv =====
`default_nettype none
module qau_lane (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire qau_pkg::lane_op_t op,
    output qau_pkg::val_t          sum,
    output qau_pkg::val_t          red
);

    logic signed [qau_pkg::PROD_W-1:0] prod_reg [qau_pkg::TERMS];
    logic [qau_pkg::TERMS-1:0]         neg_reg;
    qau_pkg::val_t                     acc_reg;
    qau_pkg::val_t                     acc_next;
    qau_pkg::val_t                     sum_reg;
    qau_pkg::val_t                     red_reg;
    qau_pkg::val_t                     red_next;

    always_comb
    begin
        acc_next = '0;
        for (int k = 0; k < qau_pkg::TERMS; k++)
        begin
            if (neg_reg[k])
                acc_next = acc_next - qau_pkg::val_t'(prod_reg[k]);
            else
                acc_next = acc_next + qau_pkg::val_t'(prod_reg[k]);
        end
    end

    // Round half up to the fixed-point grid.
    assign red_next = (acc_reg + (qau_pkg::val_t'(1) << (qau_pkg::FRAC_BITS - 1)))
                      >>> qau_pkg::FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < qau_pkg::TERMS; k++)
                prod_reg[k] <= $signed(op.x[k]) * $signed(op.y[k]);
            neg_reg <= op.neg;
            acc_reg <= acc_next;
            sum_reg <= acc_reg;
            red_reg <= red_next;
        end
    end

    assign sum = sum_reg;
    assign red = red_reg;

endmodule
`default_nettype wire

// ===== src/qau_sqrt.sv =====
`default_nettype none
module qau_sqrt (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [qau_pkg::SQ_W-1:0]     x,
    output logic      [qau_pkg::ROOT_W-1:0]   root
);

    logic [qau_pkg::SQ_W-1:0]     x_reg    [qau_pkg::SQ_STEPS-1];
    logic [qau_pkg::SQ_REM_W-1:0] rem_reg  [qau_pkg::SQ_STEPS];
    logic [qau_pkg::ROOT_W-1:0]   root_reg [qau_pkg::SQ_STEPS];
    logic [qau_pkg::ROOT_W-1:0]   round_reg;

    genvar k;
    for (k = 0; k < qau_pkg::SQ_STEPS; k++)
    begin : g_step
        logic [qau_pkg::SQ_W-1:0]     x_in;
        logic [qau_pkg::SQ_REM_W-1:0] rem_in;
        logic [qau_pkg::SQ_REM_W-1:0] rem_sh;
        logic [qau_pkg::SQ_REM_W-1:0] trial;
        logic [qau_pkg::ROOT_W-1:0]   root_in;

        if (k == 0)
        begin : g_first
            assign x_in    = x;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign x_in    = x_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // Bring down the next pair of radicand bits.
        assign rem_sh = {rem_in[qau_pkg::SQ_REM_W-3:0], x_in[qau_pkg::SQ_W-1-2*k -: 2]};
        assign trial  = qau_pkg::SQ_REM_W'({root_in, 2'b01});

        if (k < qau_pkg::SQ_STEPS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                    x_reg[k] <= x_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {root_in[qau_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {root_in[qau_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // Round to nearest: the remainder exceeds the root exactly when the true
    // root lies at or above the halfway point.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rem_reg[qau_pkg::SQ_STEPS-1] >
                qau_pkg::SQ_REM_W'(root_reg[qau_pkg::SQ_STEPS-1]))
                round_reg <= root_reg[qau_pkg::SQ_STEPS-1] + 1'b1;
            else
                round_reg <= root_reg[qau_pkg::SQ_STEPS-1];
        end
    end

    assign root = round_reg;

endmodule
`default_nettype wire

// ===== src/qau_div.sv =====
`default_nettype none
module qau_div (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [qau_pkg::NUM_W-1:0]   un,
    input  wire logic [qau_pkg::DEN_W-1:0]   ud,
    output logic      [qau_pkg::NUM_W-1:0]   q
);

    logic [qau_pkg::NUM_W-1:0] num_reg [qau_pkg::NUM_W-1];
    logic [qau_pkg::DEN_W-1:0] den_reg [qau_pkg::NUM_W-1];
    logic [qau_pkg::DEN_W-1:0] rem_reg [qau_pkg::NUM_W-1];
    logic [qau_pkg::NUM_W-1:0] q_reg   [qau_pkg::NUM_W];

    genvar j;
    for (j = 0; j < qau_pkg::NUM_W; j++)
    begin : g_step
        logic [qau_pkg::NUM_W-1:0] num_in;
        logic [qau_pkg::DEN_W-1:0] den_in;
        logic [qau_pkg::DEN_W-1:0] rem_in;
        logic [qau_pkg::NUM_W-1:0] q_in;
        logic [qau_pkg::DEN_W:0]   t;
        logic                      fits;

        if (j == 0)
        begin : g_first
            assign num_in = un;
            assign den_in = ud;
            assign rem_in = '0;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign num_in = num_reg[j-1];
            assign den_in = den_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        assign t    = {rem_in, num_in[qau_pkg::NUM_W-1-j]};
        assign fits = (t >= {1'b0, den_in});

        if (j < qau_pkg::NUM_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[j] <= num_in;
                    den_reg[j] <= den_in;
                    if (fits)
                        rem_reg[j] <= qau_pkg::DEN_W'(t - {1'b0, den_in});
                    else
                        rem_reg[j] <= t[qau_pkg::DEN_W-1:0];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                q_reg[j] <= {q_in[qau_pkg::NUM_W-2:0], fits};
        end
    end

    assign q = q_reg[qau_pkg::NUM_W-1];

endmodule
`default_nettype wire

// ===== src/quaternion_arithmetic_unit.sv =====
`default_nettype none
// Quaternion arithmetic unit in signed fixed point (qau_pkg::FRAC_BITS fraction
// bits, Q16.16 as built). Every input beat carries a command, quaternions A and
// B and a factor, and yields exactly one output beat, in order. The unit is a
// fully pipelined chain with no feedback, so it accepts one beat on every clock
// while the output side keeps up; a stall at the output freezes the whole chain
// and drops in_ch.ready in the same cycle. The long part of the chain is the
// bit-per-stage square root followed by the bit-per-stage divider, which every
// command passes through so that all commands see the same latency.
module quaternion_arithmetic_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    qau_in_if.sink    in_ch,
    qau_out_if.source out_ch
);

    localparam int DW = qau_pkg::DATA_W;
    localparam int NL = qau_pkg::LANES;

    // Data that rides alongside the lanes until their rounded sums are ready.
    typedef struct packed {
        qau_pkg::cmd_t                     cmd;
        logic [NL-1:0][DW-1:0]             a;
        logic [DW-1:0]                     f;
        logic [NL-1:0][qau_pkg::SUM_W-1:0] addsub;
    } early_t;

    // Data that rides alongside the square root.
    typedef struct packed {
        qau_pkg::cmd_t                     cmd;
        logic [NL-1:0][DW-1:0]             a;
        logic [DW-1:0]                     f;
        logic [NL-1:0][qau_pkg::SUM_W-1:0] addsub;
        logic [NL-1:0][qau_pkg::SUM_W-1:0] red;
    } mid_t;

    // Data that rides alongside the dividers up to the merge stage.
    typedef struct packed {
        qau_pkg::cmd_t                     cmd;
        logic                              dz;
        logic [NL-1:0]                     qneg;
        logic [NL-1:0][qau_pkg::SUM_W-1:0] res;
        logic [qau_pkg::SUM_W-1:0]         scalar;
    } fin_t;

    logic                          adv;
    logic                          accept;
    logic [qau_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic                          out_valid_reg;

    qau_pkg::cmd_t         cmd0_reg;
    logic [NL-1:0][DW-1:0] a0_reg;
    logic [NL-1:0][DW-1:0] b0_reg;
    logic [DW-1:0]         f0_reg;

    qau_pkg::lane_op_t lane_op  [NL];
    qau_pkg::val_t     lane_sum [NL];
    qau_pkg::val_t     lane_red [NL];

    early_t early_next;
    early_t early_reg [qau_pkg::LANE_LAT];
    mid_t   mid_next;
    mid_t   mid_reg   [qau_pkg::SQ_LAT];
    mid_t   mid_last;
    fin_t   fin_next;
    fin_t   fin_reg   [qau_pkg::DIV_LAT+1];
    fin_t   fin_last;

    logic [qau_pkg::ROOT_W-1:0] root;

    logic [qau_pkg::NUM_W-1:0] un_next [NL];
    logic [qau_pkg::NUM_W-1:0] un_reg  [NL];
    logic [qau_pkg::DEN_W-1:0] ud_next;
    logic [qau_pkg::DEN_W-1:0] ud_reg;
    logic [qau_pkg::NUM_W-1:0] quot    [NL];

    logic [DW-1:0] r_next [NL];
    logic [DW-1:0] r_reg  [NL];
    logic [DW-1:0] scalar_next;
    logic [DW-1:0] scalar_reg;
    logic          sat_next;
    logic          sat_reg;
    logic          dz_reg;

    // The whole chain moves together whenever the output register can move.
    assign adv         = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;
    assign accept      = in_ch.valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[qau_pkg::PIPE_DEPTH-2:0], accept};
            out_valid_reg <= vld_reg[qau_pkg::PIPE_DEPTH-1];
        end
    end

    // Input capture.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd0_reg  <= in_ch.command;
            a0_reg[0] <= in_ch.a_w;
            a0_reg[1] <= in_ch.a_x;
            a0_reg[2] <= in_ch.a_y;
            a0_reg[3] <= in_ch.a_z;
            b0_reg[0] <= in_ch.b_w;
            b0_reg[1] <= in_ch.b_x;
            b0_reg[2] <= in_ch.b_y;
            b0_reg[3] <= in_ch.b_z;
            f0_reg    <= in_ch.factor;
        end
    end

    // Operand routing. The Hamilton product uses one lane per output part;
    // scale uses one term per lane; dot and the sum of squares put all four
    // products into lane zero so that its sum is exact before rounding.
    always_comb
    begin
        for (int l = 0; l < NL; l++)
            lane_op[l] = '0;
        case (cmd0_reg) inside
            qau_pkg::CMD_MUL:
            begin
                for (int l = 0; l < NL; l++)
                begin
                    for (int k = 0; k < qau_pkg::TERMS; k++)
                    begin
                        lane_op[l].x[k] = a0_reg[k];
                        lane_op[l].y[k] = b0_reg[qau_pkg::MUL_BI[l][k]];
                    end
                    lane_op[l].neg = qau_pkg::MUL_NEG[l];
                end
            end
            qau_pkg::CMD_SCALE:
            begin
                for (int l = 0; l < NL; l++)
                begin
                    lane_op[l].x[0] = a0_reg[l];
                    lane_op[l].y[0] = f0_reg;
                end
            end
            qau_pkg::CMD_DOT:
            begin
                for (int k = 0; k < qau_pkg::TERMS; k++)
                begin
                    lane_op[0].x[k] = a0_reg[k];
                    lane_op[0].y[k] = b0_reg[k];
                end
            end
            qau_pkg::CMD_MAG, qau_pkg::CMD_NORM, qau_pkg::CMD_INV:
            begin
                for (int k = 0; k < qau_pkg::TERMS; k++)
                begin
                    lane_op[0].x[k] = a0_reg[k];
                    lane_op[0].y[k] = a0_reg[k];
                end
            end
            default:
            begin
            end
        endcase
    end

    genvar gl;
    for (gl = 0; gl < NL; gl++)
    begin : g_lane
        qau_lane u_lane (
            .clk (clk),
            .en  (adv),
            .op  (lane_op[gl]),
            .sum (lane_sum[gl]),
            .red (lane_red[gl])
        );
    end

    always_comb
    begin
        early_next.cmd = cmd0_reg;
        early_next.a   = a0_reg;
        early_next.f   = f0_reg;
        for (int l = 0; l < NL; l++)
        begin
            if (cmd0_reg == qau_pkg::CMD_ADD)
                early_next.addsub[l] = qau_pkg::val_t'($signed(a0_reg[l]))
                                     + qau_pkg::val_t'($signed(b0_reg[l]));
            else if (cmd0_reg == qau_pkg::CMD_SUB)
                early_next.addsub[l] = qau_pkg::val_t'($signed(a0_reg[l]))
                                     - qau_pkg::val_t'($signed(b0_reg[l]));
            else
                early_next.addsub[l] = '0;
        end
    end

    always_comb
    begin
        mid_next.cmd    = early_reg[qau_pkg::LANE_LAT-1].cmd;
        mid_next.a      = early_reg[qau_pkg::LANE_LAT-1].a;
        mid_next.f      = early_reg[qau_pkg::LANE_LAT-1].f;
        mid_next.addsub = early_reg[qau_pkg::LANE_LAT-1].addsub;
        for (int l = 0; l < NL; l++)
            mid_next.red[l] = lane_red[l];
    end

    // Lane zero holds the exact sum of squares, which is never negative.
    qau_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .x    (lane_sum[0]),
        .root (root)
    );

    assign mid_last = mid_reg[qau_pkg::SQ_LAT-1];

    // Divisor selection and operand preparation. The rounding bias of half
    // the divisor is added to the numerator magnitude ahead of the divider.
    always_comb
    begin
        logic [DW-1:0] f_mag;
        logic [DW-1:0] a_mag;
        logic          a_neg;

        f_mag = mid_last.f[DW-1] ? (~mid_last.f + 1'b1) : mid_last.f;

        fin_next.cmd    = mid_last.cmd;
        fin_next.dz     = 1'b0;
        fin_next.qneg   = '0;
        fin_next.res    = '0;
        fin_next.scalar = '0;
        ud_next         = '0;

        case (mid_last.cmd) inside
            qau_pkg::CMD_ADD, qau_pkg::CMD_SUB:
                fin_next.res = mid_last.addsub;
            qau_pkg::CMD_MUL, qau_pkg::CMD_SCALE:
                fin_next.res = mid_last.red;
            qau_pkg::CMD_DOT:
                fin_next.scalar = mid_last.red[0];
            qau_pkg::CMD_MAG:
                fin_next.scalar = qau_pkg::SUM_W'(root);
            qau_pkg::CMD_DIV:
            begin
                ud_next     = qau_pkg::DEN_W'(f_mag);
                fin_next.dz = (mid_last.f == '0);
            end
            qau_pkg::CMD_NORM:
            begin
                ud_next     = qau_pkg::DEN_W'(root);
                fin_next.dz = (root == '0);
            end
            qau_pkg::CMD_INV:
            begin
                ud_next     = mid_last.red[0][qau_pkg::DEN_W-1:0];
                fin_next.dz = (mid_last.red[0] == '0);
            end
            default:
            begin
            end
        endcase

        for (int l = 0; l < NL; l++)
        begin
            a_neg = mid_last.a[l][DW-1];
            a_mag = a_neg ? (~mid_last.a[l] + 1'b1) : mid_last.a[l];
            un_next[l] = (qau_pkg::NUM_W'(a_mag) << qau_pkg::FRAC_BITS)
                       + qau_pkg::NUM_W'(ud_next >> 1);
            if (mid_last.cmd == qau_pkg::CMD_DIV)
                fin_next.qneg[l] = a_neg ^ mid_last.f[DW-1];
            else if (mid_last.cmd == qau_pkg::CMD_INV && l != 0)
                fin_next.qneg[l] = !a_neg;
            else
                fin_next.qneg[l] = a_neg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            early_reg[0] <= early_next;
            for (int i = 1; i < qau_pkg::LANE_LAT; i++)
                early_reg[i] <= early_reg[i-1];
            mid_reg[0] <= mid_next;
            for (int i = 1; i < qau_pkg::SQ_LAT; i++)
                mid_reg[i] <= mid_reg[i-1];
            fin_reg[0] <= fin_next;
            for (int i = 1; i <= qau_pkg::DIV_LAT; i++)
                fin_reg[i] <= fin_reg[i-1];
            for (int l = 0; l < NL; l++)
                un_reg[l] <= un_next[l];
            ud_reg <= ud_next;
        end
    end

    for (gl = 0; gl < NL; gl++)
    begin : g_div
        qau_div u_div (
            .clk (clk),
            .en  (adv),
            .un  (un_reg[gl]),
            .ud  (ud_reg),
            .q   (quot[gl])
        );
    end

    assign fin_last = fin_reg[qau_pkg::DIV_LAT];

    // Merge: pick each part's source, apply the sign and clamp to 32 bits.
    always_comb
    begin
        qau_pkg::sat_t s;
        logic          any_sat;

        any_sat = 1'b0;
        for (int l = 0; l < NL; l++)
        begin
            case (fin_last.cmd) inside
                qau_pkg::CMD_DIV, qau_pkg::CMD_NORM, qau_pkg::CMD_INV:
                begin
                    if (fin_last.dz)
                        s = '0;
                    else
                        s = qau_pkg::sat_quot(quot[l], fin_last.qneg[l]);
                end
                default:
                    s = qau_pkg::sat_val($signed(fin_last.res[l]));
            endcase
            r_next[l] = s.value;
            any_sat   = any_sat | s.clamp;
        end
        s           = qau_pkg::sat_val($signed(fin_last.scalar));
        scalar_next = s.value;
        sat_next    = any_sat | s.clamp;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < NL; l++)
                r_reg[l] <= r_next[l];
            scalar_reg <= scalar_next;
            sat_reg    <= sat_next;
            dz_reg     <= fin_last.dz;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.r_w           = r_reg[0];
    assign out_ch.r_x           = r_reg[1];
    assign out_ch.r_y           = r_reg[2];
    assign out_ch.r_z           = r_reg[3];
    assign out_ch.scalar_result = scalar_reg;
    assign out_ch.div_by_zero   = dz_reg;
    assign out_ch.saturated     = sat_reg;

    // A zero divisor leaves nothing to clamp and no value in any field.
    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.div_by_zero |->
            out_ch.r_w == '0 && out_ch.r_x == '0 && out_ch.r_y == '0 &&
            out_ch.r_z == '0 && out_ch.scalar_result == '0 && !out_ch.saturated)
        else $error("division by zero beat carries data");

    // Scalar results and quaternion results never share a beat.
    a_scalar_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.scalar_result != '0 |->
            out_ch.r_w == '0 && out_ch.r_x == '0 && out_ch.r_y == '0 &&
            out_ch.r_z == '0 && !out_ch.div_by_zero)
        else $error("scalar beat carries a quaternion");

    // While the output is stalled no beat may move anywhere in the chain.
    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

// ===== test/tb_quaternion_arithmetic_unit.sv =====
`timescale 1ns / 1ps

module tb_quaternion_arithmetic_unit;

    // Wide signed working type: products and their sums stay exact in here.
    typedef logic signed [127:0] wide_t;

    typedef struct {
        qau_pkg::cmd_t command;
        logic [31:0]   a [4];
        logic [31:0]   b [4];
        logic [31:0]   factor;
    } quat_item_t;

    typedef struct {
        logic [31:0] r [4];
        logic [31:0] scalar;
        logic        div_by_zero;
        logic        saturated;
    } quat_result_t;

    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 200000;
    // Extra cycles that let the tail drain past the output latency.
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;

    localparam wide_t OUT_MAX = 64'sd2147483647;
    localparam wide_t OUT_MIN = -64'sd2147483648;

    logic clk;
    logic rst_n;

    qau_in_if  in_ch ();
    qau_out_if out_ch ();

    quaternion_arithmetic_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    quat_item_t   pending_items [$];
    quat_result_t expected_results [$];
    quat_item_t   item_on_bus;
    logic         in_beat_taken;
    int           items_driven;
    int           results_seen;
    int           error_count;
    int           cycle_count;
    int           hold_left;
    logic         hold_done;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Round to nearest with ties toward plus infinity, back to FRAC_BITS.
    function automatic wide_t round_fix(input wide_t v);
        return (v + (wide_t'(1) <<< (qau_pkg::FRAC_BITS - 1))) >>> qau_pkg::FRAC_BITS;
    endfunction

    // Quotient rounded to nearest with ties away from zero; den is nonzero.
    function automatic wide_t quotient_round(input wide_t num, input wide_t den);
        logic [127:0] un;
        logic [127:0] ud;
        logic [127:0] q;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q  = (un + ud / 2) / ud;
        return ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic wide_t sum_of_squares(input wide_t q [4]);
        wide_t s;
        s = 0;
        for (int i = 0; i < 4; i++)
        begin
            s = s + q[i] * q[i];
        end
        return s;
    endfunction

    // Exact magnitude: the square root of the sum of squares, rounded to the
    // nearest integer. A sum that reaches 2^64 reports 2^32.
    function automatic wide_t magnitude(input wide_t q [4]);
        logic [127:0] s;
        logic [127:0] root;
        logic [127:0] trial;
        s = sum_of_squares(q);
        if (s >= (128'd1 << 64))
        begin
            return wide_t'(1) <<< 32;
        end
        root = 0;
        for (int bitpos = 32; bitpos >= 0; bitpos--)
        begin
            trial = root | (128'd1 << bitpos);
            if (trial * trial <= s)
            begin
                root = trial;
            end
        end
        if (s - root * root > root)
        begin
            root = root + 1;
        end
        return $signed(root);
    endfunction

    function automatic quat_result_t predict_result(input quat_item_t it);
        quat_result_t res;
        wide_t        qa [4];
        wide_t        qb [4];
        wide_t        qr [4];
        wide_t        outs [5];
        wide_t        f;
        wide_t        sc;
        wide_t        den;
        logic         dz;
        logic         sat;
        for (int i = 0; i < 4; i++)
        begin
            qa[i] = $signed(it.a[i]);
            qb[i] = $signed(it.b[i]);
            qr[i] = 0;
        end
        f   = $signed(it.factor);
        sc  = 0;
        dz  = 1'b0;
        sat = 1'b0;

        case (it.command)
            qau_pkg::CMD_ADD: for (int i = 0; i < 4; i++) qr[i] = qa[i] + qb[i];
            qau_pkg::CMD_SUB: for (int i = 0; i < 4; i++) qr[i] = qa[i] - qb[i];
            qau_pkg::CMD_MUL:
            begin
                qr[0] = round_fix(qa[0]*qb[0] - qa[1]*qb[1] - qa[2]*qb[2] - qa[3]*qb[3]);
                qr[1] = round_fix(qa[0]*qb[1] + qa[1]*qb[0] + qa[2]*qb[3] - qa[3]*qb[2]);
                qr[2] = round_fix(qa[0]*qb[2] - qa[1]*qb[3] + qa[2]*qb[0] + qa[3]*qb[1]);
                qr[3] = round_fix(qa[0]*qb[3] + qa[1]*qb[2] - qa[2]*qb[1] + qa[3]*qb[0]);
            end
            qau_pkg::CMD_SCALE: for (int i = 0; i < 4; i++) qr[i] = round_fix(qa[i] * f);
            qau_pkg::CMD_DIV:
            begin
                if (f == 0)
                begin
                    dz = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                        qr[i] = quotient_round(qa[i] <<< qau_pkg::FRAC_BITS, f);
                end
            end
            qau_pkg::CMD_DOT:
                sc = round_fix(qa[0]*qb[0] + qa[1]*qb[1] + qa[2]*qb[2] + qa[3]*qb[3]);
            qau_pkg::CMD_MAG: sc = magnitude(qa);
            qau_pkg::CMD_NORM:
            begin
                // All four parts share the unclamped magnitude of the original A.
                den = magnitude(qa);
                if (den == 0)
                begin
                    dz = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                        qr[i] = quotient_round(qa[i] <<< qau_pkg::FRAC_BITS, den);
                end
            end
            qau_pkg::CMD_INV:
            begin
                // Conjugate over the rounded (never clamped) squared norm.
                den = round_fix(sum_of_squares(qa));
                if (den == 0)
                begin
                    dz = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        qr[i] = quotient_round(((i == 0) ? qa[i] : -qa[i])
                                               <<< qau_pkg::FRAC_BITS, den);
                    end
                end
            end
            default: ;
        endcase

        for (int i = 0; i < 4; i++) outs[i] = qr[i];
        outs[4] = sc;
        for (int i = 0; i < 5; i++)
        begin
            if (outs[i] > OUT_MAX)
            begin
                outs[i] = OUT_MAX;
                sat = 1'b1;
            end
            else if (outs[i] < OUT_MIN)
            begin
                outs[i] = OUT_MIN;
                sat = 1'b1;
            end
        end
        for (int i = 0; i < 4; i++) res.r[i] = outs[i][31:0];
        res.scalar      = outs[4][31:0];
        res.div_by_zero = dz;
        res.saturated   = sat;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Operand mix: full-range words, values near 1.0, tiny values, extremes.
    function automatic logic [31:0] random_operand();
        int mode;
        mode = $urandom_range(9);
        case (mode)
            0, 1, 2: return $urandom;
            3, 4, 5: return 32'($signed($urandom_range(262144)) - 131072);
            6:       return 32'($signed($urandom_range(64)) - 32);
            7:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            8:       return 32'($signed($urandom_range(4096)) - 2048) << 16;
            default: return 32'h0;
        endcase
    endfunction

    function automatic quat_item_t make_item(input qau_pkg::cmd_t c, input logic [31:0] aw,
                                             input logic [31:0] ax, input logic [31:0] ay,
                                             input logic [31:0] az, input logic [31:0] bw,
                                             input logic [31:0] f);
        quat_item_t it;
        it.command = c;
        it.a[0] = aw; it.a[1] = ax; it.a[2] = ay; it.a[3] = az;
        it.b[0] = bw; it.b[1] = ~ax; it.b[2] = ay ^ 32'h5A5A_0000; it.b[3] = ~az;
        it.factor = f;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Reset, stimulus and end of test
    // ------------------------------------------------------------------

    initial
    begin
        quat_item_t it;
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.command  = qau_pkg::CMD_ADD;
        in_ch.a_w = '0; in_ch.a_x = '0; in_ch.a_y = '0; in_ch.a_z = '0;
        in_ch.b_w = '0; in_ch.b_x = '0; in_ch.b_y = '0; in_ch.b_z = '0;
        in_ch.factor   = '0;
        out_ch.ready   = 1'b0;
        error_count    = 0;
        items_driven   = 0;
        results_seen   = 0;
        hold_left      = 0;
        hold_done      = 1'b0;

        // Directed part: field extremes, every command, and the special cases.
        pending_items.push_back(make_item(qau_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000,
                                          32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 32'h0));
        pending_items.push_back(make_item(qau_pkg::CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF,
                                          32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0));
        pending_items.push_back(make_item(qau_pkg::CMD_MUL, 32'h0001_0000, 32'h0002_0000,
                                          32'hFFFF_8000, 32'h0000_8000, 32'h0003_0000, 32'h0));
        pending_items.push_back(make_item(qau_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000,
                                          32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0));
        pending_items.push_back(make_item(qau_pkg::CMD_SCALE, 32'h0001_8000, 32'hFFFF_0000,
                                          32'h0000_0001, 32'h7FFF_FFFF, 32'h0, 32'h0000_8000));
        pending_items.push_back(make_item(qau_pkg::CMD_SCALE, 32'h8000_0000, 32'h7FFF_FFFF,
                                          32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000));
        pending_items.push_back(make_item(qau_pkg::CMD_DIV, 32'h0001_0000, 32'h0002_0000,
                                          32'h0, 32'hFFFF_0000, 32'h0, 32'h0));
        pending_items.push_back(make_item(qau_pkg::CMD_DIV, 32'h0003_0000, 32'hFFFF_0000,
                                          32'h0000_0001, 32'h7FFF_FFFF, 32'h0, 32'h0002_0000));
        pending_items.push_back(make_item(qau_pkg::CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000,
                                          32'h0001_0000, 32'h0, 32'h0, 32'h0000_0001));
        pending_items.push_back(make_item(qau_pkg::CMD_DIV, 32'h8000_0000, 32'h0001_0000,
                                          32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF));
        pending_items.push_back(make_item(qau_pkg::CMD_DOT, 32'h0001_0000, 32'h0002_0000,
                                          32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 32'h0));
        pending_items.push_back(make_item(qau_pkg::CMD_DOT, 32'h8000_0000, 32'h8000_0000,
                                          32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0));
        pending_items.push_back(make_item(qau_pkg::CMD_MAG, 32'h0, 32'h0, 32'h0, 32'h0,
                                          32'h0, 32'h0));
        pending_items.push_back(make_item(qau_pkg::CMD_MAG, 32'h0003_0000, 32'h0004_0000,
                                          32'h0, 32'h0, 32'h0, 32'h0));
        pending_items.push_back(make_item(qau_pkg::CMD_MAG, 32'h8000_0000, 32'h8000_0000,
                                          32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
        pending_items.push_back(make_item(qau_pkg::CMD_NORM, 32'h0, 32'h0, 32'h0, 32'h0,
                                          32'h0, 32'h0));
        pending_items.push_back(make_item(qau_pkg::CMD_NORM, 32'h0001_0000, 32'hFFFF_0000,
                                          32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0));
        pending_items.push_back(make_item(qau_pkg::CMD_NORM, 32'h0000_0001, 32'h0, 32'h0,
                                          32'h0, 32'h0, 32'h0));
        pending_items.push_back(make_item(qau_pkg::CMD_INV, 32'h0000_0001, 32'h0, 32'h0,
                                          32'h0, 32'h0, 32'h0));
        pending_items.push_back(make_item(qau_pkg::CMD_INV, 32'h0, 32'h0, 32'h0, 32'h0,
                                          32'h0, 32'h0));
        pending_items.push_back(make_item(qau_pkg::CMD_INV, 32'h0002_0000, 32'h0001_0000,
                                          32'hFFFF_0000, 32'h0000_8000, 32'h0, 32'h0));
        pending_items.push_back(make_item(qau_pkg::CMD_INV, 32'h0000_0100, 32'h0, 32'h0,
                                          32'h0, 32'h0, 32'h0));
        pending_items.push_back(make_item(qau_pkg::cmd_t'(9), 32'h7FFF_FFFF, 32'h1, 32'h2,
                                          32'h3, 32'h4, 32'h5));
        pending_items.push_back(make_item(qau_pkg::cmd_t'(15), 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF));

        // Random part: mostly defined commands, a few unused codes.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(19) == 0)
            begin
                it.command = qau_pkg::cmd_t'($urandom_range(15, 9));
            end
            else
            begin
                it.command = qau_pkg::cmd_t'($urandom_range(8));
            end
            for (int i = 0; i < 4; i++)
            begin
                it.a[i] = random_operand();
                it.b[i] = random_operand();
            end
            it.factor = random_operand();
            pending_items.push_back(it);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_items.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard stop if the block stops moving.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial cycle_count = 0;

    // ------------------------------------------------------------------
    // Input driver: changes on the falling edge. A beat is held until the
    // rising edge that takes it; idling is skipped for a middle stretch.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic idle;
        if (rst_n && (!in_ch.valid || in_beat_taken))
        begin
            idle = (items_driven < 600 || items_driven > 1000) && ($urandom_range(99) < 23);
            if (pending_items.size() != 0 && !idle)
            begin
                item_on_bus    = pending_items.pop_front();
                items_driven   = items_driven + 1;
                in_ch.valid   <= 1'b1;
                in_ch.command <= item_on_bus.command;
                in_ch.a_w     <= item_on_bus.a[0];
                in_ch.a_x     <= item_on_bus.a[1];
                in_ch.a_y     <= item_on_bus.a[2];
                in_ch.a_z     <= item_on_bus.a[3];
                in_ch.b_w     <= item_on_bus.b[0];
                in_ch.b_x     <= item_on_bus.b[1];
                in_ch.b_y     <= item_on_bus.b[2];
                in_ch.b_z     <= item_on_bus.b[3];
                in_ch.factor  <= item_on_bus.factor;
            end
            else
            begin
                in_ch.valid   <= 1'b0;
            end
        end
    end

    // Input beats are detected at the rising edge, and the result they will
    // produce is predicted right away.
    always @(posedge clk)
    begin
        in_beat_taken = in_ch.valid && in_ch.ready;
        if (in_beat_taken)
        begin
            expected_results.push_back(predict_result(item_on_bus));
        end
    end

    // ------------------------------------------------------------------
    // Output side: random back-pressure, one long hold-off once the pipe
    // has had time to fill, so the input side is forced to stall.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && results_seen == 300)
            begin
                hold_left     = HOLD_CYCLES;
                hold_done     = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left     = hold_left - 1;
                out_ch.ready <= 1'b0;
            end
            else if (results_seen >= 700 && results_seen < 1100)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= 23);
            end
        end
    end

    // Result checker: compares every output beat with the oldest prediction.
    always @(posedge clk)
    begin
        quat_result_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            results_seen = results_seen + 1;
            if (expected_results.size() == 0)
            begin
                $error("output beat with no prediction pending");
                error_count = error_count + 1;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_ch.r_w !== want.r[0])
                begin
                    $error("r_w expected %h actual %h", want.r[0], out_ch.r_w);
                    error_count = error_count + 1;
                end
                if (out_ch.r_x !== want.r[1])
                begin
                    $error("r_x expected %h actual %h", want.r[1], out_ch.r_x);
                    error_count = error_count + 1;
                end
                if (out_ch.r_y !== want.r[2])
                begin
                    $error("r_y expected %h actual %h", want.r[2], out_ch.r_y);
                    error_count = error_count + 1;
                end
                if (out_ch.r_z !== want.r[3])
                begin
                    $error("r_z expected %h actual %h", want.r[3], out_ch.r_z);
                    error_count = error_count + 1;
                end
                if (out_ch.scalar_result !== want.scalar)
                begin
                    $error("scalar_result expected %h actual %h", want.scalar,
                           out_ch.scalar_result);
                    error_count = error_count + 1;
                end
                if (out_ch.div_by_zero !== want.div_by_zero)
                begin
                    $error("div_by_zero expected %b actual %b", want.div_by_zero,
                           out_ch.div_by_zero);
                    error_count = error_count + 1;
                end
                if (out_ch.saturated !== want.saturated)
                begin
                    $error("saturated expected %b actual %b", want.saturated,
                           out_ch.saturated);
                    error_count = error_count + 1;
                end
            end
        end
    end

endmodule

// ===== sim.f =====
src/qau_pkg.sv
src/qau_in_if.sv
src/qau_out_if.sv
src/qau_lane.sv
src/qau_sqrt.sv
src/qau_div.sv
src/quaternion_arithmetic_unit.sv
test/tb_quaternion_arithmetic_unit.sv
